// File: sv/u16seg_pkg.sv
package u16seg_pkg;

    localparam int CU_W      = 16;
    localparam int OUT_OFF_W = 21;
    localparam int CLASS_W   = 3;
    localparam int SLOTS     = 3;
    localparam int SLOT_W    = 2;
    localparam int RES_W     = 2 * OUT_OFF_W + CLASS_W;
    localparam int TDATA_W   = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - RES_W;

    localparam logic [CLASS_W-1:0] CLASS_SPACE = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_LATIN = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_HIRA  = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_KATA  = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_KANJI = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_PUNCT = 3'd5;
    localparam logic [CLASS_W-1:0] CLASS_OTHER = 3'd6;
    localparam logic [CLASS_W-1:0] CLASS_BREAK = 3'd7;

    localparam logic [CU_W-1:0] CU_CR       = 16'h000D;
    localparam logic [CU_W-1:0] CU_LF       = 16'h000A;
    localparam logic [CU_W-1:0] CU_ZWJ      = 16'h200D;
    localparam logic [CU_W-1:0] CU_SEL_HIGH = 16'hDB40;

    // one result, unit_start in the lowest bits
    typedef struct packed {
        logic [CLASS_W-1:0]   unit_class;
        logic [OUT_OFF_W-1:0] unit_end;
        logic [OUT_OFF_W-1:0] unit_start;
    } result_t;

    // every result caused by one code unit
    typedef struct packed {
        logic [SLOT_W-1:0]   count;
        logic                text_done;
        result_t [SLOTS-1:0] slot;
    } bundle_t;

    function automatic logic in_rng(input logic [CU_W-1:0] c, input logic [CU_W-1:0] lo,
                                    input logic [CU_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic is_high(input logic [CU_W-1:0] c);
        return in_rng(c, 16'hD800, 16'hDBFF);
    endfunction

    function automatic logic is_low(input logic [CU_W-1:0] c);
        return in_rng(c, 16'hDC00, 16'hDFFF);
    endfunction

    function automatic logic is_extender(input logic [CU_W-1:0] c);
        return in_rng(c, 16'h0300, 16'h036F) || in_rng(c, 16'h1AB0, 16'h1AFF) ||
               in_rng(c, 16'h1DC0, 16'h1DFF) || in_rng(c, 16'h20D0, 16'h20FF) ||
               in_rng(c, 16'hFE20, 16'hFE2F) || in_rng(c, 16'hFE00, 16'hFE0F);
    endfunction

    // pair decodes to U+E0100..U+E01EF
    function automatic logic is_selector_pair(input logic [CU_W-1:0] h,
                                              input logic [CU_W-1:0] c);
        return (h == CU_SEL_HIGH) && in_rng(c, 16'hDD00, 16'hDDEF);
    endfunction

    function automatic logic [CLASS_W-1:0] classify(input logic [CU_W-1:0] c);
        logic [CLASS_W-1:0] r;
        if (c == 16'h0020 || c == 16'h0009 || c == 16'h3000)
            r = CLASS_SPACE;
        else if (in_rng(c, 16'h0030, 16'h0039) || in_rng(c, 16'h0041, 16'h005A) ||
                 in_rng(c, 16'h0061, 16'h007A) || c == 16'h005F ||
                 in_rng(c, 16'hFF10, 16'hFF19) || in_rng(c, 16'hFF21, 16'hFF3A) ||
                 in_rng(c, 16'hFF41, 16'hFF5A))
            r = CLASS_LATIN;
        else if (in_rng(c, 16'h3040, 16'h309F))
            r = CLASS_HIRA;
        else if (in_rng(c, 16'h30A0, 16'h30FF) || in_rng(c, 16'hFF66, 16'hFF9F))
            r = CLASS_KATA;
        else if (in_rng(c, 16'h3400, 16'h9FFF))
            r = CLASS_KANJI;
        else if (in_rng(c, 16'h2000, 16'h206F) || in_rng(c, 16'h3000, 16'h303F) ||
                 in_rng(c, 16'hFF00, 16'hFF65) || in_rng(c, 16'h0021, 16'h002F) ||
                 in_rng(c, 16'h003A, 16'h0040) || in_rng(c, 16'h005B, 16'h0060) ||
                 in_rng(c, 16'h007B, 16'h007E))
            r = CLASS_PUNCT;
        else
            r = CLASS_OTHER;
        return r;
    endfunction

endpackage

// File: sv/u16seg_front.sv
module u16seg_front #(
    parameter int OFFSET_BITS = 21
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [u16seg_pkg::CU_W-1:0] code_unit,
    input  logic                      text_end,
    output logic                      push,
    output u16seg_pkg::bundle_t       bundle
);
    import u16seg_pkg::*;

    localparam logic [2:0] MODE_EXT       = 3'd0;
    localparam logic [2:0] MODE_EXT_HIGH  = 3'd1;
    localparam logic [2:0] MODE_BASE_HIGH = 3'd2;
    localparam logic [2:0] MODE_AFTER_ZWJ = 3'd3;
    localparam logic [2:0] MODE_CR        = 3'd4;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    logic [OFFSET_BITS-1:0] position_reg, position_next;
    logic                   open_reg, open_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [CLASS_W-1:0]     class_reg, class_next;
    logic [2:0]             mode_reg, mode_next;
    logic [CU_W-1:0]        held_reg, held_next;

    logic [OFFSET_BITS-1:0] pos, nxt, prev;
    logic                   do_ext, do_start;
    logic [SLOT_W-1:0]      n;

    function automatic result_t mk(input logic [OFFSET_BITS-1:0] s,
                                   input logic [OFFSET_BITS-1:0] e,
                                   input logic [CLASS_W-1:0] c);
        result_t r;
        r.unit_start = OUT_OFF_W'(s);
        r.unit_end   = OUT_OFF_W'(e);
        r.unit_class = c;
        return r;
    endfunction

    always_comb
    begin
        pos  = position_reg;
        nxt  = (pos == OFF_MAX) ? pos : pos + 1'b1;
        prev = (pos == '0) ? pos : pos - 1'b1;

        open_next  = open_reg;
        start_next = start_reg;
        class_next = class_reg;
        mode_next  = mode_reg;
        held_next  = held_reg;
        do_ext     = 1'b0;
        do_start   = 1'b0;
        n          = '0;
        bundle     = '0;

        // dispatch on what the open unit is waiting for
        if (!open_reg)
        begin
            do_start = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_EXT_HIGH:
                begin
                    if (!(is_low(code_unit) && is_selector_pair(held_reg, code_unit)))
                    begin
                        if (n < 2'd3)
                        begin
                            bundle.slot[n] = mk(start_next, prev, class_next);
                            n = n + 2'd1;
                        end
                        start_next = prev;
                        class_next = classify(held_reg);
                    end
                    mode_next = MODE_EXT;
                    do_ext    = !is_low(code_unit);
                end
                MODE_BASE_HIGH:
                begin
                    mode_next = MODE_EXT;
                    do_ext    = !is_low(code_unit);
                end
                MODE_AFTER_ZWJ:
                begin
                    if (is_high(code_unit))
                    begin
                        mode_next = MODE_BASE_HIGH;
                        held_next = code_unit;
                    end
                    else
                    begin
                        mode_next = MODE_EXT;
                    end
                end
                MODE_CR:
                begin
                    if (code_unit == CU_LF)
                    begin
                        if (n < 2'd3)
                        begin
                            bundle.slot[n] = mk(start_next, nxt, CLASS_BREAK);
                            n = n + 2'd1;
                        end
                        open_next = 1'b0;
                        mode_next = MODE_EXT;
                    end
                    else
                    begin
                        if (n < 2'd3)
                        begin
                            bundle.slot[n] = mk(start_next, pos, CLASS_BREAK);
                            n = n + 2'd1;
                        end
                        do_start = 1'b1;
                    end
                end
                default:
                begin
                    do_ext = 1'b1;
                end
            endcase
        end

        // code unit in extending position
        if (do_ext)
        begin
            if (is_extender(code_unit))
            begin
                mode_next = MODE_EXT;
            end
            else if (is_high(code_unit))
            begin
                mode_next = MODE_EXT_HIGH;
                held_next = code_unit;
            end
            else if (code_unit == CU_ZWJ)
            begin
                mode_next = MODE_AFTER_ZWJ;
            end
            else
            begin
                if (n < 2'd3)
                begin
                    bundle.slot[n] = mk(start_next, pos, class_next);
                    n = n + 2'd1;
                end
                do_start = 1'b1;
            end
        end

        // code unit opens a new unit
        if (do_start)
        begin
            start_next = pos;
            if (code_unit == CU_CR)
            begin
                open_next  = 1'b1;
                class_next = CLASS_BREAK;
                mode_next  = MODE_CR;
            end
            else if (code_unit == CU_LF)
            begin
                if (n < 2'd3)
                begin
                    bundle.slot[n] = mk(pos, nxt, CLASS_BREAK);
                    n = n + 2'd1;
                end
                open_next = 1'b0;
                mode_next = MODE_EXT;
            end
            else
            begin
                open_next  = 1'b1;
                class_next = classify(code_unit);
                if (is_high(code_unit))
                begin
                    mode_next = MODE_BASE_HIGH;
                    held_next = code_unit;
                end
                else
                begin
                    mode_next = MODE_EXT;
                end
            end
        end

        position_next = nxt;

        // close everything at the end of the text
        if (text_end)
        begin
            if (open_next)
            begin
                if (mode_next == MODE_EXT_HIGH)
                begin
                    if (n < 2'd3)
                    begin
                        bundle.slot[n] = mk(start_next, pos, class_next);
                        n = n + 2'd1;
                    end
                    if (n < 2'd3)
                    begin
                        bundle.slot[n] = mk(pos, nxt, classify(held_next));
                        n = n + 2'd1;
                    end
                end
                else if (n < 2'd3)
                begin
                    bundle.slot[n] = mk(start_next, nxt, class_next);
                    n = n + 2'd1;
                end
            end
            position_next = '0;
            open_next     = 1'b0;
            start_next    = '0;
            class_next    = '0;
            mode_next     = MODE_EXT;
            held_next     = '0;
        end

        bundle.count     = n;
        bundle.text_done = text_end;
        push             = accept && (n != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            open_reg     <= 1'b0;
            start_reg    <= '0;
            class_reg    <= '0;
            mode_reg     <= MODE_EXT;
            held_reg     <= '0;
        end
        else if (accept)
        begin
            position_reg <= position_next;
            open_reg     <= open_next;
            start_reg    <= start_next;
            class_reg    <= class_next;
            mode_reg     <= mode_next;
            held_reg     <= held_next;
        end
    end

endmodule

// File: sv/u16seg_queue.sv
module u16seg_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u16seg_pkg::bundle_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output u16seg_pkg::bundle_t head
);
    import u16seg_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bundle_t          entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign head    = entry_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_reg] <= push_data;
    end

endmodule

// File: sv/u16seg_back.sv
module u16seg_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           empty,
    input  u16seg_pkg::bundle_t            head,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output u16seg_pkg::result_t            out_result,
    output logic                           out_last,
    output logic                           out_final
);
    import u16seg_pkg::*;

    logic              valid_reg, valid_next;
    result_t           result_reg;
    logic              last_reg;
    logic              final_reg;
    logic [SLOT_W-1:0] sel_reg, sel_next;
    logic              load, head_last;

    // one result per cycle from the head bundle into the output register, while it is empty or out_ready
    assign load      = !empty && (!valid_reg || out_ready);
    assign head_last = (sel_reg == head.count - 2'd1);
    assign pop       = load && head_last;

    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sel_next   = head_last ? '0 : sel_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= head.slot[sel_reg];
            last_reg   <= head_last;
            final_reg  <= head_last && head.text_done;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
    assign out_last   = last_reg;
    assign out_final  = final_reg;

endmodule

// File: sv/utf16_text_unit_segmenter.sv
// Splits a UTF-16 stream into user-perceived units (CR LF, surrogate pairs, base plus
// combining marks and selectors, ZWJ sequences) and emits each with its start offset, end
// offset and class. A code unit is taken every cycle while the bundle queue has room; one
// code unit can close up to three units, and the output sends one unit per cycle while
// m_tready is high, so the input is throttled when units come out faster than one per
// code unit or the output stalls. A closed unit goes via the bundle queue to the output
// register. Text ends with tlast on the input; the final unit of a text carries tuser
// set, and tlast on the output marks the last unit caused by one input code unit.
module utf16_text_unit_segmenter #(
    parameter int OFFSET_BITS = 21,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [u16seg_pkg::CU_W-1:0]       s_tdata,   // [15:0] code_unit
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [u16seg_pkg::TDATA_W-1:0]    m_tdata,   // [20:0] unit_start, [41:21] unit_end,
                                                         // [44:42] unit_class, [47:45] zero
    output logic                              m_tuser,   // [0] final_of_text
    output logic                              m_tlast
);
    import u16seg_pkg::*;

    logic    accept, push, full, empty, pop;
    bundle_t bundle, head;
    result_t out_result;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    u16seg_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_unit (s_tdata),
        .text_end  (s_tlast),
        .push      (push),
        .bundle    (bundle)
    );

    u16seg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (bundle),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    u16seg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result),
        .out_last   (m_tlast),
        .out_final  (m_tuser)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_result};

endmodule

// File: sv/u16seg_checker.sv
module u16seg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [u16seg_pkg::TDATA_W-1:0]    m_tdata,
    input logic                              m_tuser,
    input logic                              m_tlast
);
    import u16seg_pkg::*;

    // a stalled transaction keeps its contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output changed while stalled");

    // the final unit of a text is also the last of its run
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("final unit without run end");

    // the unit after the end of a text starts a new text at offset zero
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser |=> !m_tvalid || m_tdata[OUT_OFF_W-1:0] == '0)
        else $error("next text does not start at zero");

    // padding bits stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[TDATA_W-1:RES_W] == '0)
        else $error("padding bits set");

endmodule

bind utf16_text_unit_segmenter u16seg_checker u_checker (.*);
